// ===== sv/spq_pkg.sv =====
package spq_pkg;

   // operation codes carried by req_func
   typedef logic [1:0] func_type;
   localparam func_type FUNC_PUSH = 2'd0;
   localparam func_type FUNC_POP  = 2'd1;
   localparam func_type FUNC_PEEK = 2'd2;

   // status codes carried by rsp_status
   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_EMPTY = 2'd1;
   localparam status_type STATUS_FULL  = 2'd2;

endpackage

// ===== sv/sorted_priority_queue_top.sv =====
// Sorted priority queue of up to DEPTH entries, highest priority served first and equal
// priorities in arrival order. Issue a word with start while busy is low; one result word
// appears on the rsp_ ports for a single cycle with rsp_valid, and the receiver cannot hold it
// off. A refused push, a pop or peek of an empty queue, and an unused code answer in the cycle
// after start. A peek reads the head and answers. A push moves each stored entry of lower
// priority one slot toward the tail, starting from the tail, then writes the new entry; a pop
// answers with the head, then moves each remaining entry one slot toward the head. The two-port
// entry memory (one read and one write a cycle) serves one sequencer with one priority comparator.
module sorted_priority_queue_top #(
   parameter int DEPTH          = 16,
   parameter int DATA_WIDTH     = 32,
   parameter int PRIORITY_WIDTH = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  spq_pkg::func_type           req_func,
   input  logic [PRIORITY_WIDTH-1:0]   req_prio_in,
   input  logic [DATA_WIDTH-1:0]       req_data_in,
   output logic                        rsp_valid,
   output logic [DATA_WIDTH-1:0]       rsp_data_out,
   output logic [PRIORITY_WIDTH-1:0]   rsp_prio_out,
   output spq_pkg::status_type         rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]  rsp_count_out,
   output logic                        rsp_empty_out
);
   import spq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int EW = PRIORITY_WIDTH + DATA_WIDTH;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_entry;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [EW-1:0] rd_entry;

   // sequencer with the shared priority comparator
   spq_seq #(
      .DEPTH          (DEPTH),
      .DATA_WIDTH     (DATA_WIDTH),
      .PRIORITY_WIDTH (PRIORITY_WIDTH)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_prio_in   (req_prio_in),
      .req_data_in   (req_data_in),
      .rsp_valid     (rsp_valid),
      .rsp_data_out  (rsp_data_out),
      .rsp_prio_out  (rsp_prio_out),
      .rsp_status    (rsp_status),
      .rsp_count_out (rsp_count_out),
      .rsp_empty_out (rsp_empty_out),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_entry      (wr_entry),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_entry      (rd_entry)
   );

   // sorted entry memory, head at address zero
   spq_store #(
      .DEPTH       (DEPTH),
      .ENTRY_WIDTH (EW)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry)
   );

endmodule

// ===== sv/spq_store.sv =====
module spq_store #(
   parameter int DEPTH       = 16,
   parameter int ENTRY_WIDTH = 40
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [ENTRY_WIDTH-1:0]       wr_entry,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [ENTRY_WIDTH-1:0]       rd_entry
);

   logic [ENTRY_WIDTH-1:0] mem_ff [DEPTH];
   logic [ENTRY_WIDTH-1:0] rd_entry_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_entry;
      end
   end

   // single registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

// ===== sv/spq_seq.sv =====
module spq_seq #(
   parameter int DEPTH          = 16,
   parameter int DATA_WIDTH     = 32,
   parameter int PRIORITY_WIDTH = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  spq_pkg::func_type                    req_func,
   input  logic [PRIORITY_WIDTH-1:0]            req_prio_in,
   input  logic [DATA_WIDTH-1:0]                req_data_in,
   output logic                                 rsp_valid,
   output logic [DATA_WIDTH-1:0]                rsp_data_out,
   output logic [PRIORITY_WIDTH-1:0]            rsp_prio_out,
   output spq_pkg::status_type                  rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]           rsp_count_out,
   output logic                                 rsp_empty_out,
   output logic                                 wr_en,
   output logic [$clog2(DEPTH)-1:0]             wr_addr,
   output logic [PRIORITY_WIDTH+DATA_WIDTH-1:0] wr_entry,
   output logic                                 rd_en,
   output logic [$clog2(DEPTH)-1:0]             rd_addr,
   input  logic [PRIORITY_WIDTH+DATA_WIDTH-1:0] rd_entry
);
   import spq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PUSH = 2'd1;
   localparam logic [1:0] ST_HEAD = 2'd2;
   localparam logic [1:0] ST_POP  = 2'd3;

   logic [1:0]                state_ff, state_in;
   logic [AW-1:0]             k_ff, k_in;
   logic [CW-1:0]             count_ff, count_in;
   func_type                  op_ff, op_in;
   logic [PRIORITY_WIDTH-1:0] prio_ff, prio_in;
   logic [DATA_WIDTH-1:0]     data_ff, data_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]     rsp_data_ff, rsp_data_in;
   logic [PRIORITY_WIDTH-1:0] rsp_prio_ff, rsp_prio_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic [CW-1:0]             rsp_count_ff, rsp_count_in;

   logic [PRIORITY_WIDTH-1:0] rd_prio;
   logic [DATA_WIDTH-1:0]     rd_data;
   logic                      place_here;

   assign rd_prio = rd_entry[DATA_WIDTH +: PRIORITY_WIDTH];
   assign rd_data = rd_entry[DATA_WIDTH-1:0];

   // shared compare: new entry stops behind an entry of greater or equal priority
   assign place_here = (k_ff == '0) || (rd_prio >= prio_ff);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      prio_in       = prio_ff;
      data_in       = data_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = k_ff;
      wr_entry      = {prio_ff, data_ff};
      rd_en         = 1'b0;
      rd_addr       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in   = req_func;
               prio_in = req_prio_in;
               data_in = req_data_in;
               rsp_data_in   = '0;
               rsp_prio_in   = '0;
               rsp_status_in = STATUS_OK;
               rsp_count_in  = count_ff;
               unique case (req_func) inside
                  FUNC_PUSH: begin
                     if (count_ff == CW'(DEPTH)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        // walk from the tail, reading the last stored word
                        k_in     = count_ff[AW-1:0];
                        rd_en    = (count_ff != '0);
                        rd_addr  = AW'(count_ff - 1'b1);
                        state_in = ST_PUSH;
                     end
                  end
                  FUNC_POP, FUNC_PEEK: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        state_in = ST_HEAD;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_PUSH: begin
            wr_en   = 1'b1;
            wr_addr = k_ff;
            if (place_here) begin
               wr_entry     = {prio_ff, data_ff};
               count_in     = count_ff + 1'b1;
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff + 1'b1;
               state_in     = ST_IDLE;
            end else begin
               // move the lower-priority word one slot toward the tail
               wr_entry = rd_entry;
               k_in     = k_ff - 1'b1;
               rd_en    = (k_ff > AW'(1));
               rd_addr  = (k_ff - 1'b1) - 1'b1;
            end
         end
         ST_HEAD: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = rd_data;
            rsp_prio_in  = rd_prio;
            if (op_ff == FUNC_POP) begin
               count_in     = count_ff - 1'b1;
               rsp_count_in = count_ff - 1'b1;
               if (count_ff > CW'(1)) begin
                  k_in     = '0;
                  rd_en    = 1'b1;
                  rd_addr  = AW'(1);
                  state_in = ST_POP;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_POP: begin
            // close the gap left by the head, one word a cycle
            wr_en    = 1'b1;
            wr_addr  = k_ff;
            wr_entry = rd_entry;
            if (CW'(k_ff) + 1'b1 == count_ff) begin
               state_in = ST_IDLE;
            end else begin
               k_in    = k_ff + 1'b1;
               rd_en   = 1'b1;
               rd_addr = (k_ff + 1'b1) + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      op_ff         <= op_in;
      prio_ff       <= prio_in;
      data_ff       <= data_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data_out  = rsp_data_ff;
   assign rsp_prio_out  = rsp_prio_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_count_out = rsp_count_ff;
   assign rsp_empty_out = (rsp_count_ff == '0);

   // checks
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUSH) |-> (CW'(k_ff) <= count_ff))
      else $error("push walk beyond stored entries");

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_PUSH && count_ff == CW'(DEPTH))
      |=> (rsp_valid && rsp_status == STATUS_FULL && $stable(count_ff)))
      else $error("push on full queue not refused");

   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff != ST_IDLE))
      else $error("store written while idle");

endmodule
